### design/lkfr_pkg.sv
`default_nettype none

package lkfr_pkg;

  // Fixed field and register widths
  localparam int CMD_W     = 2;
  localparam int STATUS_W  = 3;
  localparam int TS_W      = 64;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_K_W   = 4;
  localparam int CFG_CAP_W = 7;
  localparam int CFG_W     = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_ACCESS    = 2'd0,
    CMD_SET_EVICT = 2'd1,
    CMD_REMOVE    = 2'd2,
    CMD_EVICT     = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_UNKNOWN   = 3'd2,
    ST_PINNED    = 3'd3,
    ST_NO_VICTIM = 3'd4
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HISTORY_K = 1'd0,
    REG_CAPACITY  = 1'd1
  } cfg_reg_t;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_RD   = 6'b000010,
    S_EXEC = 6'b000100,
    S_SCAN = 6'b001000,
    S_FIN  = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

endpackage

`default_nettype wire

### design/lkfr_ram.sv
`default_nettype none

module lkfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### design/lru_k_frame_replacer.sv
`default_nettype none

// LRU-K frame replacer for a buffer pool. Each accepted item is one command
// (record access, set evictable, remove, evict) and yields exactly one result
// with a status code and the evictable frame count. Record access, set
// evictable and remove pass a read and an execute state; evict runs a scan
// that reads one frame per cycle through the per-frame metadata RAM and then
// the history RAM, feeding a single 64-bit compare unit, then a finish state.
// The history RAM (FRAME_COUNT * MAX_K words of 64 bits) needs no clearing
// after reset. A new item is taken only after the previous result has been
// accepted. The user must write configuration while idle; it is not enforced.
module lru_k_frame_replacer #(
  parameter int FRAME_COUNT = 64,
  parameter int MAX_K       = 8
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // command channel
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [lkfr_pkg::CMD_W-1:0]        in_command,
  input  wire logic [$clog2(FRAME_COUNT)-1:0]    in_frame,
  input  wire logic                              in_evictable_value,
  // result channel
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic                                   out_victim_valid,
  output logic      [$clog2(FRAME_COUNT)-1:0]    out_victim_frame,
  output logic      [lkfr_pkg::STATUS_W-1:0]     out_status,
  output logic      [$clog2(FRAME_COUNT+1)-1:0]  out_evictable_count,
  // configuration
  input  wire logic                              cfg_we,
  input  wire logic [lkfr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [lkfr_pkg::CFG_W-1:0]        cfg_wdata
);

  localparam int FRAME_W = $clog2(FRAME_COUNT);
  localparam int IDX_W   = FRAME_W + 1;
  localparam int CNT_W   = $clog2(FRAME_COUNT + 1);
  localparam int K_W     = $clog2(MAX_K + 1);
  localparam int PTR_W   = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam int META_W  = K_W + PTR_W;
  localparam int HDEPTH  = FRAME_COUNT * MAX_K;
  localparam int HA_W    = $clog2(HDEPTH);
  localparam int D_W     = K_W + 1;
  localparam int KC_W    = (K_W > lkfr_pkg::CFG_K_W) ? K_W : lkfr_pkg::CFG_K_W;
  localparam int CMP_W   = (CNT_W > lkfr_pkg::CFG_CAP_W) ? CNT_W : lkfr_pkg::CFG_CAP_W;
  localparam int TS_W    = lkfr_pkg::TS_W;

  // control and bookkeeping
  lkfr_pkg::state_t              state_r;
  lkfr_pkg::cmd_t                cmd_r;
  logic [FRAME_W-1:0]            frame_r;
  logic                          val_r;
  logic [FRAME_COUNT-1:0]        tracked_r;
  logic [FRAME_COUNT-1:0]        evict_r;
  logic [CNT_W-1:0]              tracked_cnt_r;
  logic [CNT_W-1:0]              evict_cnt_r;
  logic [TS_W-1:0]               ts_r;
  logic [lkfr_pkg::CFG_K_W-1:0]  history_k_r;
  logic [lkfr_pkg::CFG_CAP_W-1:0] capacity_r;

  // scan pipeline
  logic [IDX_W-1:0]              scan_idx_r;
  logic                          p1_valid_r;
  logic [FRAME_W-1:0]            p1_idx_r;
  logic                          p1_elig_r;
  logic                          p2_valid_r;
  logic [FRAME_W-1:0]            p2_idx_r;
  logic                          p2_elig_r;
  logic                          p2_inf_r;
  logic                          found_r;
  logic                          best_inf_r;
  logic [TS_W-1:0]               best_t_r;
  logic [FRAME_W-1:0]            best_idx_r;

  // result registers
  logic                          out_vv_r;
  logic [FRAME_W-1:0]            out_vf_r;
  lkfr_pkg::status_t             out_st_r;
  logic [CNT_W-1:0]              out_cnt_r;

  // RAM ports
  logic [FRAME_W-1:0]            meta_raddr;
  logic [META_W-1:0]             meta_rdata;
  logic                          meta_we;
  logic [META_W-1:0]             meta_wdata;
  logic [HA_W-1:0]               hist_raddr;
  logic [TS_W-1:0]               hist_rdata;
  logic                          hist_we;
  logic [HA_W-1:0]               hist_waddr;

  // derived values
  logic [K_W-1:0]                eff_k;
  logic [K_W-1:0]                meta_cnt;
  logic [PTR_W-1:0]              meta_ptr;
  logic                          frame_ok;
  logic                          is_tr;
  logic                          is_ev;
  logic                          full;
  logic [K_W-1:0]                base_cnt;
  logic [PTR_W-1:0]              base_ptr;
  logic [K_W-1:0]                new_cnt;
  logic [PTR_W-1:0]              new_ptr;
  logic                          p1_inf;
  logic [K_W-1:0]                back_n;
  logic [D_W-1:0]                slot_sum;
  logic [D_W-1:0]                slot;
  logic                          better;
  logic [CNT_W-1:0]              ecnt_dec;
  logic [CNT_W-1:0]              tcnt_dec;

  lkfr_ram #(.WIDTH(META_W), .DEPTH(FRAME_COUNT)) u_meta_ram (
    .clk   (clk),
    .we    (meta_we),
    .waddr (frame_r),
    .wdata (meta_wdata),
    .raddr (meta_raddr),
    .rdata (meta_rdata)
  );

  lkfr_ram #(.WIDTH(TS_W), .DEPTH(HDEPTH)) u_hist_ram (
    .clk   (clk),
    .we    (hist_we),
    .waddr (hist_waddr),
    .wdata (ts_r),
    .raddr (hist_raddr),
    .rdata (hist_rdata)
  );

  // Clamp K into 1..MAX_K
  always_comb begin
    if (history_k_r == '0) begin
      eff_k = K_W'(1);
    end else if (KC_W'(history_k_r) > KC_W'(MAX_K)) begin
      eff_k = K_W'(MAX_K);
    end else begin
      eff_k = K_W'(KC_W'(history_k_r));
    end
  end

  assign meta_cnt = meta_rdata[META_W-1 -: K_W];
  assign meta_ptr = meta_rdata[PTR_W-1:0];
  assign frame_ok = {1'b0, frame_r} < IDX_W'(FRAME_COUNT);
  assign is_tr    = tracked_r[frame_r];
  assign is_ev    = evict_r[frame_r];
  assign full     = CMP_W'(tracked_cnt_r) >= CMP_W'(capacity_r);
  assign ecnt_dec = (evict_cnt_r != '0) ? evict_cnt_r - 1'b1 : evict_cnt_r;
  assign tcnt_dec = (tracked_cnt_r != '0) ? tracked_cnt_r - 1'b1 : tracked_cnt_r;

  // Record access: push the timestamp into the frame's ring
  always_comb begin
    base_cnt   = is_tr ? meta_cnt : '0;
    base_ptr   = is_tr ? meta_ptr : '0;
    new_ptr    = (base_ptr == PTR_W'(MAX_K - 1)) ? '0 : base_ptr + 1'b1;
    new_cnt    = (base_cnt == K_W'(MAX_K)) ? base_cnt : base_cnt + 1'b1;
    hist_we    = (state_r == lkfr_pkg::S_EXEC) && (cmd_r == lkfr_pkg::CMD_ACCESS) &&
                 frame_ok && (is_tr || !full);
    meta_we    = hist_we;
    meta_wdata = {new_cnt, new_ptr};
    hist_waddr = HA_W'(frame_r) * HA_W'(MAX_K) + HA_W'(base_ptr);
  end

  // Scan stage 1: pick the history slot to compare
  always_comb begin
    meta_raddr = (state_r == lkfr_pkg::S_SCAN) ? scan_idx_r[FRAME_W-1:0] : frame_r;
    p1_inf     = meta_cnt < eff_k;
    back_n     = p1_inf ? K_W'(1) : eff_k;
    slot_sum   = D_W'(meta_ptr) + D_W'(MAX_K) - D_W'(back_n);
    slot       = (slot_sum >= D_W'(MAX_K)) ? slot_sum - D_W'(MAX_K) : slot_sum;
    hist_raddr = HA_W'(p1_idx_r) * HA_W'(MAX_K) + HA_W'(slot);
  end

  // Scan stage 2: shared compare against the best candidate so far
  assign better = !found_r || (p2_inf_r && !best_inf_r) ||
                  ((p2_inf_r == best_inf_r) && (hist_rdata < best_t_r));

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      history_k_r <= lkfr_pkg::CFG_K_W'(2);
      capacity_r  <= lkfr_pkg::CFG_CAP_W'(64);
    end else if (cfg_we) begin
      case (lkfr_pkg::cfg_reg_t'(cfg_index))
        lkfr_pkg::REG_HISTORY_K: history_k_r <= cfg_wdata[lkfr_pkg::CFG_K_W-1:0];
        lkfr_pkg::REG_CAPACITY:  capacity_r  <= cfg_wdata[lkfr_pkg::CFG_CAP_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= lkfr_pkg::S_IDLE;
      tracked_r     <= '0;
      evict_r       <= '0;
      tracked_cnt_r <= '0;
      evict_cnt_r   <= '0;
      ts_r          <= '0;
      p1_valid_r    <= 1'b0;
      p2_valid_r    <= 1'b0;
      found_r       <= 1'b0;
      scan_idx_r    <= '0;
    end else begin
      // advance the scan pipeline
      p2_valid_r <= p1_valid_r;
      p2_idx_r   <= p1_idx_r;
      p2_elig_r  <= p1_elig_r;
      p2_inf_r   <= p1_inf;
      p1_valid_r <= 1'b0;
      if (p2_valid_r && p2_elig_r && better) begin
        found_r    <= 1'b1;
        best_inf_r <= p2_inf_r;
        best_t_r   <= hist_rdata;
        best_idx_r <= p2_idx_r;
      end

      case (state_r)
        lkfr_pkg::S_IDLE: begin
          if (in_valid) begin
            cmd_r   <= lkfr_pkg::cmd_t'(in_command);
            frame_r <= in_frame;
            val_r   <= in_evictable_value;
            if (lkfr_pkg::cmd_t'(in_command) == lkfr_pkg::CMD_EVICT) begin
              scan_idx_r <= '0;
              found_r    <= 1'b0;
              state_r    <= lkfr_pkg::S_SCAN;
            end else begin
              state_r <= lkfr_pkg::S_RD;
            end
          end
        end

        lkfr_pkg::S_RD: begin
          state_r <= lkfr_pkg::S_EXEC;
        end

        lkfr_pkg::S_EXEC: begin
          out_vv_r  <= 1'b0;
          out_vf_r  <= '0;
          out_st_r  <= lkfr_pkg::ST_OK;
          out_cnt_r <= evict_cnt_r;
          state_r   <= lkfr_pkg::S_OUT;
          if (!frame_ok) begin
            out_st_r <= lkfr_pkg::ST_UNKNOWN;
          end else begin
            case (cmd_r)
              lkfr_pkg::CMD_ACCESS: begin
                if (is_tr) begin
                  ts_r <= ts_r + 1'b1;
                end else if (full) begin
                  out_st_r <= lkfr_pkg::ST_FULL;
                end else begin
                  tracked_r[frame_r] <= 1'b1;
                  evict_r[frame_r]   <= 1'b0;
                  tracked_cnt_r      <= tracked_cnt_r + 1'b1;
                  ts_r               <= ts_r + 1'b1;
                end
              end
              lkfr_pkg::CMD_SET_EVICT: begin
                if (!is_tr) begin
                  out_st_r <= lkfr_pkg::ST_UNKNOWN;
                end else begin
                  evict_r[frame_r] <= val_r;
                  if (is_ev && !val_r) begin
                    evict_cnt_r <= ecnt_dec;
                    out_cnt_r   <= ecnt_dec;
                  end else if (!is_ev && val_r) begin
                    evict_cnt_r <= evict_cnt_r + 1'b1;
                    out_cnt_r   <= evict_cnt_r + 1'b1;
                  end
                end
              end
              lkfr_pkg::CMD_REMOVE: begin
                if (!is_tr) begin
                  out_st_r <= lkfr_pkg::ST_UNKNOWN;
                end else if (!is_ev) begin
                  out_st_r <= lkfr_pkg::ST_PINNED;
                end else begin
                  tracked_r[frame_r] <= 1'b0;
                  evict_r[frame_r]   <= 1'b0;
                  tracked_cnt_r      <= tcnt_dec;
                  evict_cnt_r        <= ecnt_dec;
                  out_cnt_r          <= ecnt_dec;
                end
              end
              default: ;
            endcase
          end
        end

        lkfr_pkg::S_SCAN: begin
          // issue one frame per cycle, then drain
          if (scan_idx_r != IDX_W'(FRAME_COUNT)) begin
            p1_valid_r <= 1'b1;
            p1_idx_r   <= scan_idx_r[FRAME_W-1:0];
            p1_elig_r  <= tracked_r[scan_idx_r[FRAME_W-1:0]] &
                          evict_r[scan_idx_r[FRAME_W-1:0]];
            scan_idx_r <= scan_idx_r + 1'b1;
          end else if (!p1_valid_r && !p2_valid_r) begin
            state_r <= lkfr_pkg::S_FIN;
          end
        end

        lkfr_pkg::S_FIN: begin
          state_r <= lkfr_pkg::S_OUT;
          if (found_r) begin
            tracked_r[best_idx_r] <= 1'b0;
            evict_r[best_idx_r]   <= 1'b0;
            tracked_cnt_r         <= tcnt_dec;
            evict_cnt_r           <= ecnt_dec;
            out_cnt_r             <= ecnt_dec;
            out_vv_r              <= 1'b1;
            out_vf_r              <= best_idx_r;
            out_st_r              <= lkfr_pkg::ST_OK;
          end else begin
            out_cnt_r <= evict_cnt_r;
            out_vv_r  <= 1'b0;
            out_vf_r  <= '0;
            out_st_r  <= lkfr_pkg::ST_NO_VICTIM;
          end
        end

        lkfr_pkg::S_OUT: begin
          if (out_ready) begin
            state_r <= lkfr_pkg::S_IDLE;
          end
        end

        default: begin
          state_r <= lkfr_pkg::S_IDLE;
        end
      endcase
    end
  end

  // Handshake and result ports
  assign in_ready            = (state_r == lkfr_pkg::S_IDLE);
  assign out_valid           = (state_r == lkfr_pkg::S_OUT);
  assign out_victim_valid    = out_vv_r;
  assign out_victim_frame    = out_vf_r;
  assign out_status          = out_st_r;
  assign out_evictable_count = out_cnt_r;

endmodule

`default_nettype wire
